FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers included by the trigger core; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, prop, msg)

`endif

`endif

FILE: design/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Types, sizes and constants of the spectral tree trigger.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int FRAMES    = 32;
   localparam int BINS      = 6;
   localparam int NODES     = 8;
   localparam int SAMPLE_W  = 16;
   localparam int POWER_W   = 32;
   localparam int REG_IDX_W = $clog2(NODES);
   localparam int REQ_W     = 2 * BINS * SAMPLE_W;
   localparam int RSP_W     = 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [POWER_W-1:0]         power_type;
   typedef power_type [BINS-1:0]       frame_type;
   typedef frame_type [FRAMES-1:0]     ring_type;
   typedef power_type [NODES-1:0]      thr_array_type;

   // Threshold register indexes, one per tree node
   typedef enum logic [REG_IDX_W-1:0] {
      REG_THR_A,
      REG_THR_B,
      REG_THR_C,
      REG_THR_D,
      REG_THR_E,
      REG_THR_F,
      REG_THR_G,
      REG_THR_H
   } reg_index_type;

   localparam power_type THR_RESET [NODES] = '{
      32'd32603, 32'd213062, 32'd24741, 32'd30347,
      32'd6188,  32'd789,    32'd37587, 32'd34760
   };

   // Ring position each node looks at, counted from bin 0 of the oldest frame
   localparam int NODE_POS [NODES] = '{96, 90, 187, 2, 144, 179, 140, 176};

endpackage

FILE: design/stt_bin_power.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_bin_power
// Power of one complex bin, re*re + im*im, exact in unsigned Q32.0.
// ----------------------------------------------------------------------------
module stt_bin_power
   import stt_pkg::*;
(
   input  sample_type re_i,
   input  sample_type im_i,
   output power_type  power_o
);

   logic signed [2*SAMPLE_W-1:0] re_sq;
   logic signed [2*SAMPLE_W-1:0] im_sq;

   // Each square is at most 2^30, so the sum fits 32 bits unsigned
   assign re_sq   = re_i * re_i;
   assign im_sq   = im_i * im_i;
   assign power_o = POWER_W'(unsigned'(re_sq)) + POWER_W'(unsigned'(im_sq));

endmodule

FILE: design/stt_frame_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_frame_cell
// One frame slot of the power ring; hands its frame to the next slot on shift.
// ----------------------------------------------------------------------------
module stt_frame_cell
   import stt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_i,
   input  frame_type frame_i,
   input  logic      valid_i,
   output frame_type frame_o,
   output logic      valid_o,
   output frame_type tap_o
);

   frame_type frame_ff;
   logic      valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_i) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_i) begin
         frame_ff <= frame_i;
      end
   end

   // A slot never written reads as zero
   always_comb begin
      for (int b = 0; b < BINS; b++) begin
         tap_o[b] = valid_ff ? frame_ff[b] : '0;
      end
   end

   assign frame_o = frame_ff;
   assign valid_o = valid_ff;

endmodule

FILE: design/stt_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_tree
// Eight-node decision tree over fixed ring positions.
// ----------------------------------------------------------------------------
module stt_tree
   import stt_pkg::*;
(
   input  ring_type      taps_i,
   input  thr_array_type thr_i,
   output logic          trigger_o
);

   logic [NODES-1:0] le;

   // Slot 0 holds the newest frame, so the oldest frame sits in slot FRAMES-1
   for (genvar n = 0; n < NODES; n++) begin : g_node
      localparam int Cell = FRAMES - 1 - NODE_POS[n] / BINS;
      localparam int Bin  = NODE_POS[n] % BINS;
      assign le[n] = (taps_i[Cell][Bin] <= thr_i[n]);
   end

   always_comb begin
      if (le[REG_THR_A]) begin
         trigger_o = !le[REG_THR_B];
      end else if (le[REG_THR_E]) begin
         trigger_o = le[REG_THR_C] & le[REG_THR_D] & le[REG_THR_F];
      end else begin
         trigger_o = le[REG_THR_C] & le[REG_THR_D] & le[REG_THR_G] & le[REG_THR_H];
      end
   end

endmodule

FILE: design/spectral_tree_trigger_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_tree_trigger_core
// Per-frame bin powers into a 32-frame ring of cells, then a threshold tree.
// ----------------------------------------------------------------------------
// Pipeline: three registered stages from request accept to rsp_tvalid (square,
// ring shift, tree compare).
// Throughput: one request per cycle while the response side keeps up; the ring shifts once per request.
// Reset (synchronous, active high): ring slots invalid (read as zero),
// thresholds back to their defaults, pipeline empty. No clearing pass.
module spectral_tree_trigger_core
   import stt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Request: bin0_re, bin0_im, bin1_re, ... bin5_im, 16 bits each from bit 0
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   // Response: trigger in bit 0, upper bits zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,
   // Threshold writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [POWER_W-1:0]   csr_wdata
);

`include "assert_macros.svh"

   // ---------------------------------------------------------------------
   // Pipeline control: square stage (a), ring stage (c), output register
   // ---------------------------------------------------------------------
   logic          a_valid_ff, a_valid_in;
   frame_type     a_power_ff;
   frame_type     a_power_in;
   logic          c_valid_ff, c_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_trig_ff, rsp_trig_in;
   thr_array_type thr_ff, thr_in;

   logic req_take;
   logic a_adv;
   logic c_adv;
   logic verdict;

   // Each stage advances when the stage below is empty or moving on
   always_comb begin
      c_adv      = c_valid_ff & (!rsp_valid_ff | rsp_tready);
      a_adv      = a_valid_ff & (!c_valid_ff | c_adv);
      req_tready = !a_valid_ff | a_adv;
      req_take   = req_tvalid & req_tready;
   end

   // ---------------------------------------------------------------------
   // Square stage: six bin powers in parallel
   // ---------------------------------------------------------------------
   for (genvar b = 0; b < BINS; b++) begin : g_bin
      stt_bin_power u_power (
         .re_i    (sample_type'(req_tdata[2*b*SAMPLE_W +: SAMPLE_W])),
         .im_i    (sample_type'(req_tdata[(2*b+1)*SAMPLE_W +: SAMPLE_W])),
         .power_o (a_power_in[b])
      );
   end

   always_comb begin
      a_valid_in = req_take | (a_valid_ff & !a_adv);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_power_ff <= a_power_in;
      end
   end

   // ---------------------------------------------------------------------
   // Ring: slot 0 takes the new frame, every slot hands its frame onward,
   // the oldest frame drops off the far end
   // ---------------------------------------------------------------------
   ring_type          cell_frame;
   logic [FRAMES-1:0] cell_valid;
   ring_type          cell_tap;

   for (genvar f = 0; f < FRAMES; f++) begin : g_cell
      if (f == 0) begin : g_head
         stt_frame_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_i (a_adv),
            .frame_i (a_power_ff),
            .valid_i (1'b1),
            .frame_o (cell_frame[f]),
            .valid_o (cell_valid[f]),
            .tap_o   (cell_tap[f])
         );
      end else begin : g_body
         stt_frame_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift_i (a_adv),
            .frame_i (cell_frame[f-1]),
            .valid_i (cell_valid[f-1]),
            .frame_o (cell_frame[f]),
            .valid_o (cell_valid[f]),
            .tap_o   (cell_tap[f])
         );
      end
   end

   always_comb begin
      c_valid_in = a_adv | (c_valid_ff & !c_adv);
   end

   // ---------------------------------------------------------------------
   // Tree: read the ring after the shift; a shift at the same edge as c_adv
   // belongs to the next request, so the verdict still sees this one's ring
   // ---------------------------------------------------------------------
   stt_tree u_tree (
      .taps_i    (cell_tap),
      .thr_i     (thr_ff),
      .trigger_o (verdict)
   );

   always_comb begin
      rsp_valid_in = c_adv | (rsp_valid_ff & !rsp_tready);
      rsp_trig_in  = c_adv ? verdict : rsp_trig_ff;
   end

   // ---------------------------------------------------------------------
   // Threshold registers: always ready, not guarded by the block; to be written only while idle
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (csr_valid) begin
         thr_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < NODES; n++) begin
            thr_ff[n] <= THR_RESET[n];
         end
      end else begin
         a_valid_ff   <= a_valid_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_trig_ff <= rsp_trig_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, rsp_trig_ff};

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `ASSERT_CLK(a_shift_marks_ring, clock, reset, a_adv |=> c_valid_ff, "ring shift lost its request")
   `ASSERT_CLK(a_shift_fills_head, clock, reset, a_adv |=> cell_valid[0], "head slot not filled")
   `ASSERT_CLK(a_rsp_from_ring, clock, reset, (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(c_valid_ff), "response without ring stage")
   `ASSERT_CLK(a_ready_when_empty, clock, reset, !a_valid_ff |-> req_tready, "stalled with empty square stage")
   `ASSERT_NEVER(a_no_overrun, clock, reset, a_adv && c_valid_ff && !c_adv, "ring shifted under pending verdict")

endmodule

FILE: test/spectral_tree_trigger_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_tree_trigger_core_tb
// Self-checking bench for the bin-power ring and threshold tree trigger.
// Frames go in over the request stream. A bench-side copy of the power ring
// and of the eight-node tree predicts each verdict, and every response is
// checked in order against it. Threshold programs change between drained
// phases, both stream sides idle at random, and one long response hold
// backs the block up into its request port.
// ----------------------------------------------------------------------------
module spectral_tree_trigger_core_tb;
   import stt_pkg::*;

   // One request: bin0_re in the lowest 16 bits, then bin0_im, bin1_re, ...
   typedef sample_type [2*BINS-1:0] bin_frame_t;

   localparam sample_type S_MIN = 16'sh8000;
   localparam sample_type S_MAX = 16'sh7FFF;
   localparam int RING_LEN   = FRAMES * BINS;
   localparam int LEAVES     = 9;
   localparam int LONG_HOLD  = 300;
   localparam int SETTLE_CYC = 12;

   // Ring position that each tree node compares, from bin 0 of the oldest frame
   localparam int NODE_AT [NODES] = '{96, 90, 187, 2, 144, 179, 140, 176};
   localparam power_type TREE_THR_DEFAULT [NODES] = '{
      32'd32603, 32'd213062, 32'd24741, 32'd30347,
      32'd6188,  32'd789,    32'd37587, 32'd34760
   };

   // Clock, reset and ports; every input is known from time zero
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;  // bin0_re, bin0_im, ... bin5_im
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;        // trigger, then zero pad
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [REG_IDX_W-1:0] csr_index  = '0;
   logic [POWER_W-1:0]   csr_wdata  = '0;

   always #5 clock = ~clock;

   spectral_tree_trigger_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Bench copy of the block state: power ring, write frame, thresholds
   // ------------------------------------------------------------------------
   power_type   power_ring [RING_LEN];
   logic [4:0]  head_frame;
   power_type   tree_thr [NODES];
   bit          leaf_hit [LEAVES];

   // Verdicts still owed by the block, oldest first
   bit          verdict_q [$];

   // Run statistics and traffic knobs
   int unsigned req_gap_pct   = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned mismatch_count   = 0;
   int unsigned frames_sent      = 0;
   int unsigned verdicts_checked = 0;
   int unsigned triggers_seen    = 0;
   int unsigned thr_programs     = 0;
   int unsigned longest_in_stall = 0;

   // Exact values a node can be hit with in the tree-path phase
   sample_type  eq_re [NODES];
   sample_type  eq_im [NODES];

   // Long response hold: bump hold_serial to start one
   int unsigned hold_serial = 0;
   int unsigned hold_seen   = 0;
   int unsigned hold_left   = 0;

   function automatic power_type bin_power(input sample_type re, input sample_type im);
      int sr;
      int si;
      sr = re;
      si = im;
      return power_type'(sr * sr) + power_type'(si * si);
   endfunction

   function automatic power_type ring_at(input int pos);
      return power_ring[(pos + BINS * head_frame) % RING_LEN];
   endfunction

   // Walk the fixed tree; a node goes low when value <= threshold
   function automatic bit tree_verdict(output int leaf);
      if (ring_at(NODE_AT[REG_THR_A]) <= tree_thr[REG_THR_A]) begin
         leaf = (ring_at(NODE_AT[REG_THR_B]) > tree_thr[REG_THR_B]) ? 1 : 0;
         return leaf == 1;
      end
      if (ring_at(NODE_AT[REG_THR_C]) > tree_thr[REG_THR_C]) begin
         leaf = 2;
         return 1'b0;
      end
      if (ring_at(NODE_AT[REG_THR_D]) > tree_thr[REG_THR_D]) begin
         leaf = 3;
         return 1'b0;
      end
      if (ring_at(NODE_AT[REG_THR_E]) <= tree_thr[REG_THR_E]) begin
         leaf = (ring_at(NODE_AT[REG_THR_F]) <= tree_thr[REG_THR_F]) ? 4 : 5;
         return leaf == 4;
      end
      if (ring_at(NODE_AT[REG_THR_G]) > tree_thr[REG_THR_G]) begin
         leaf = 6;
         return 1'b0;
      end
      leaf = (ring_at(NODE_AT[REG_THR_H]) <= tree_thr[REG_THR_H]) ? 7 : 8;
      return leaf == 7;
   endfunction

   // Store the frame's powers, advance the write frame, then judge
   function automatic bit predict_verdict(input bin_frame_t fr);
      int leaf;
      bit fire;
      for (int b = 0; b < BINS; b++) begin
         power_ring[head_frame * BINS + b] = bin_power(fr[2*b], fr[2*b+1]);
      end
      head_frame = head_frame + 1'b1;
      fire = tree_verdict(leaf);
      leaf_hit[leaf] = 1'b1;
      return fire;
   endfunction

   function automatic sample_type random_sample(input bit narrow);
      int v;
      if (narrow) begin
         v = $urandom_range(400, 0);
         return sample_type'(v - 200);
      end
      return sample_type'($urandom);
   endfunction

   function automatic sample_type extreme_sample();
      case ($urandom_range(3, 0))
         0:       return S_MAX;
         1:       return S_MIN;
         2:       return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   // Mix of zero, full-scale, small and wide bins so both sides of every
   // threshold come up
   function automatic bin_frame_t random_frame();
      bin_frame_t fr;
      int pick;
      for (int b = 0; b < BINS; b++) begin
         pick = $urandom_range(99, 0);
         if (pick < 8) begin
            fr[2*b]   = '0;
            fr[2*b+1] = '0;
         end else if (pick < 15) begin
            fr[2*b]   = S_MIN;
            fr[2*b+1] = S_MIN;
         end else if (pick < 25) begin
            fr[2*b]   = extreme_sample();
            fr[2*b+1] = extreme_sample();
         end else begin
            fr[2*b]   = random_sample(pick < 65);
            fr[2*b+1] = random_sample(pick < 65);
         end
      end
      return fr;
   endfunction

   // ------------------------------------------------------------------------
   // Stream and register drivers; each is entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_frame(input bin_frame_t fr);
      int waited;
      // idle the request side for a random stretch
      while ($urandom_range(99, 0) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= fr;
      waited = 0;
      @(posedge clock);
      while (!req_tready) begin
         waited++;
         @(posedge clock);
      end
      if (waited > longest_in_stall) longest_in_stall = waited;
      verdict_q.push_back(predict_verdict(fr));
      frames_sent++;
      @(negedge clock);
   endtask

   task automatic stop_requests();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until every owed verdict has come back
   task automatic drain();
      while (verdict_q.size() != 0) @(negedge clock);
   endtask

   // Write all eight thresholds back to back; only call with the block idle
   task automatic program_thresholds(input power_type vals [NODES]);
      for (int i = 0; i < NODES; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tree_thr[i] = vals[i];
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      thr_programs++;
      @(negedge clock);
   endtask

   // Fill all 32 frames so that the last verdict of the set walks a chosen
   // path: each node position is forced low, high, exactly on its threshold,
   // or left random
   task automatic send_steered_set();
      bin_frame_t batch [FRAMES];
      int f;
      int b;
      for (int i = 0; i < FRAMES; i++) batch[i] = random_frame();
      for (int n = 0; n < NODES; n++) begin
         f = NODE_AT[n] / BINS;
         b = NODE_AT[n] % BINS;
         case ($urandom_range(3, 0))
            0: begin
               batch[f][2*b]   = '0;
               batch[f][2*b+1] = '0;
            end
            1: begin
               batch[f][2*b]   = S_MIN;
               batch[f][2*b+1] = S_MIN;
            end
            2: begin
               batch[f][2*b]   = eq_re[n];
               batch[f][2*b+1] = eq_im[n];
            end
            default: ;
         endcase
      end
      for (int i = 0; i < FRAMES; i++) send_frame(batch[i]);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Full-scale, zero and bit-pattern frames on a fresh, partly empty ring
   task automatic test_directed_extremes();
      bin_frame_t plan [$];
      bin_frame_t fr;
      plan.push_back('0);
      plan.push_back({12{S_MAX}});
      plan.push_back({12{S_MIN}});
      plan.push_back({12{-16'sd1}});
      plan.push_back({12{16'sd1}});
      plan.push_back({12{16'h5555}});
      plan.push_back({12{16'hAAAA}});
      plan.push_back({6{S_MAX, S_MIN}});
      plan.push_back({6{16'sd0, S_MIN}});
      plan.push_back({6{S_MIN, 16'sd0}});
      plan.push_back({12{16'sh0080}});
      plan.push_back({12{16'sh007F}});
      plan.push_back({12{16'shFF80}});
      // one full-power bin at a time
      for (int b = 0; b < BINS; b++) begin
         fr = '0;
         fr[2*b]   = S_MIN;
         fr[2*b+1] = S_MIN;
         plan.push_back(fr);
      end
      foreach (plan[i]) send_frame(plan[i]);
      stop_requests();
      drain();
   endtask

   // Thresholds at zero, at all ones and straddling the largest power
   task automatic test_threshold_extremes();
      power_type t [NODES];
      for (int s = 0; s < 3; s++) begin
         for (int n = 0; n < NODES; n++) begin
            case (s)
               0:       t[n] = '0;
               1:       t[n] = '1;
               default: t[n] = n[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
         end
         program_thresholds(t);
         repeat (100) send_frame(random_frame());
         stop_requests();
         drain();
      end
   endtask

   // Thresholds set to reachable powers, then whole-ring sets steered
   // down the tree branches, equality cases included
   task automatic test_tree_paths();
      power_type t [NODES];
      for (int s = 0; s < 4; s++) begin
         for (int n = 0; n < NODES; n++) begin
            eq_re[n] = random_sample($urandom_range(3, 0) != 0);
            eq_im[n] = random_sample($urandom_range(3, 0) != 0);
            t[n] = bin_power(eq_re[n], eq_im[n]);
         end
         program_thresholds(t);
         repeat (4) send_steered_set();
         stop_requests();
         drain();
      end
   endtask

   // Hold off the response side for a long stretch while requests keep
   // coming, so the pipeline fills and stalls req_tready
   task automatic test_input_backpressure();
      hold_serial++;
      repeat (150) send_frame(random_frame());
      stop_requests();
      drain();
   endtask

   // Free-running traffic under wide random, small and default thresholds
   task automatic test_random_mix();
      power_type t [NODES];
      for (int s = 0; s < 3; s++) begin
         for (int n = 0; n < NODES; n++) begin
            case (s)
               0:       t[n] = $urandom;
               1:       t[n] = $urandom_range(131072, 0);
               default: t[n] = TREE_THR_DEFAULT[n];
            endcase
         end
         program_thresholds(t);
         repeat (150) send_frame(random_frame());
         stop_requests();
         drain();
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls plus the long hold
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_serial != hold_seen) begin
         hold_seen <= hold_serial;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // Check each accepted response against the oldest owed verdict
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: response with nothing owed, expected none, actual 0x%0h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = verdict_q.pop_front();
            verdicts_checked++;
            if (rsp_tdata[0]) triggers_seen++;
            if (rsp_tdata[0] !== want) begin
               $display("%0t: trigger mismatch, expected %0b, actual %0b",
                        $time, want, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_W-1:1] !== '0) begin
               $display("%0t: response pad mismatch, expected 0, actual 0x%0h",
                        $time, rsp_tdata[RSP_W-1:1]);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      int leaves_reached;
      // clean ring, write frame zero, default thresholds
      foreach (power_ring[i]) power_ring[i] = '0;
      head_frame = '0;
      foreach (tree_thr[i]) tree_thr[i] = TREE_THR_DEFAULT[i];
      foreach (leaf_hit[i]) leaf_hit[i] = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles lightly, receiver stalls heavily
      req_gap_pct   = 26;
      rsp_stall_pct = 76;
      test_directed_extremes();
      test_threshold_extremes();

      // and the other way round
      req_gap_pct   = 76;
      rsp_stall_pct = 26;
      test_tree_paths();

      // no random idling from here on
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_input_backpressure();
      test_random_mix();

      // let any stray response show up before judging
      repeat (SETTLE_CYC) @(negedge clock);

      leaves_reached = 0;
      foreach (leaf_hit[i]) if (leaf_hit[i]) leaves_reached++;
      $display("Covered %0d frames and %0d verdicts (%0d triggers) over %0d threshold programs.",
               frames_sent, verdicts_checked, triggers_seen, thr_programs);
      $display("Reached %0d of %0d tree leaves; longest request stall %0d cycles.",
               leaves_reached, LEAVES, longest_in_stall);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("%0t: timed out with %0d verdicts still owed", $time, verdict_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
